// ===== rtl/flow_lookup_learn_core_macros.svh =====
// assertion macros for the flow lookup and learning core
`ifndef FLOW_LOOKUP_LEARN_CORE_MACROS_SVH
`define FLOW_LOOKUP_LEARN_CORE_MACROS_SVH
`ifndef SYNTH
`define FLK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define FLK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FLK_ASSERT_IMP(lbl, ante, cons)
`define FLK_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/flk_pkg.sv =====
// shared types and constants for the flow lookup and learning core
`default_nettype none
package flk_pkg;
    localparam int FLOW_ENTRIES = 256;
    localparam int ADDR_W       = $clog2(FLOW_ENTRIES);
    localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
    localparam int KEY_W        = 104;
    localparam int FLOW_ID_W    = 9;
    localparam int POLICY_W     = 16;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
    } t_flk_in;

    typedef struct packed {
        logic [FLOW_ID_W-1:0] flow_id;
        logic                 new_flow;
        logic [POLICY_W-1:0]  new_policy;
        logic                 table_full;
    } t_flk_out;

    // id = slot + 1, keeping only the low bits of the result field
    function automatic logic [FLOW_ID_W-1:0] slot_to_id(input logic [31:0] slot);
        logic [31:0] id;
        id = slot + 32'd1;
        return id[FLOW_ID_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/flk_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module flk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/flow_lookup_learn_core.sv =====
// top level of the five-tuple flow lookup and learning core
// usage:
//   input channel i_in_valid / o_in_stall carries one five-tuple per beat;
//   output channel o_out_valid / i_out_stall returns one result beat per item.
//   a beat moves at a rising edge where valid is high and stall is low.
//   default policy is written through i_cfg_we / i_cfg_wdata while idle.
// timing:
//   stored keys are read one per cycle from the key ram and compared with the
//   latched key. a miss scans every learned flow, a hit stops at the matching
//   flow, then the S_OUT state loads the output register once it is free.
//   the input stalls until that item is done, so the scan of the single ram
//   read port sets the rate of items; a new five-tuple is taken only in idle.
//   the next item is taken while a finished result still waits downstream.
// reset:
//   synchronous active-low reset empties the table (fill count back to zero),
//   clears the policy and drops any pending result; ram contents are kept.
// stall:
//   a held result stays on o_out_data; a finished lookup waits for the
//   output register before it completes, so no result is lost.
`default_nettype none
`include "flow_lookup_learn_core_macros.svh"
module flow_lookup_learn_core
    import flk_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [POLICY_W-1:0] i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_flk_in             i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_flk_out                 o_out_data
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state              r_state;
    t_flk_in             r_key;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_pend;
    logic [ADDR_W-1:0]   r_cmp_idx;
    logic [POLICY_W-1:0] r_policy;
    t_flk_out            r_res;
    logic                r_out_valid;
    t_flk_out            r_out;

    logic             w_rd_en;
    logic [KEY_W-1:0] w_rd_data;
    logic             w_hit;
    logic             w_miss;
    logic             w_full;
    logic             w_wr_en;
    logic             w_out_free;

    assign w_rd_en    = (r_state == S_SCAN) && (r_rd_idx < r_used);
    assign w_hit      = (r_state == S_SCAN) && r_pend && (w_rd_data == r_key);
    assign w_miss     = (r_state == S_SCAN) && !r_pend && !w_rd_en;
    assign w_full     = (r_used == CNT_W'(FLOW_ENTRIES));
    assign w_wr_en    = w_miss && !w_full;
    assign w_out_free = !r_out_valid || !i_out_stall;

    flk_ram #(
        .WIDTH(KEY_W),
        .DEPTH(FLOW_ENTRIES)
    ) u_key_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_used[ADDR_W-1:0]),
        .i_wr_data(r_key),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(r_rd_idx[ADDR_W-1:0]),
        .o_rd_data(w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_policy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key    <= i_in_data;
                        r_rd_idx <= '0;
                        r_pend   <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_rd_en) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    r_pend    <= w_rd_en && !w_hit;
                    r_cmp_idx <= r_rd_idx[ADDR_W-1:0];
                    if (w_hit) begin
                        r_res.flow_id    <= slot_to_id(32'(r_cmp_idx));
                        r_res.new_flow   <= 1'b0;
                        r_res.new_policy <= '0;
                        r_res.table_full <= 1'b0;
                        r_state          <= S_OUT;
                    end else if (w_miss) begin
                        if (w_full) begin
                            r_res.flow_id    <= '0;
                            r_res.new_flow   <= 1'b0;
                            r_res.new_policy <= '0;
                            r_res.table_full <= 1'b1;
                        end else begin
                            r_res.flow_id    <= slot_to_id(32'(r_used));
                            r_res.new_flow   <= 1'b1;
                            r_res.new_policy <= r_policy;
                            r_res.table_full <= 1'b0;
                            r_used           <= r_used + CNT_W'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `FLK_ASSERT_IMP(a_write_has_room, w_wr_en, r_used < CNT_W'(FLOW_ENTRIES))
    `FLK_ASSERT_NXT(a_write_bumps_count, w_wr_en, r_used == $past(r_used) + CNT_W'(1))
    `FLK_ASSERT_IMP(a_no_pending_read_idle, r_state == S_IDLE, !r_pend)
endmodule
`default_nettype wire

// ===== tb/sv/flow_lookup_learn_core_test.sv =====
// self-checking testbench for the five-tuple flow lookup and learning core
`timescale 1ns / 1ps
module flow_lookup_learn_core_test;
    import flk_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = FLOW_ENTRIES + 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [POLICY_W-1:0] cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_flk_in             in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_flk_out            out_data;

    t_flk_in             flow_table [FLOW_ENTRIES];
    int                  learned_count = 0;
    logic [POLICY_W-1:0] policy_reg = '0;
    t_flk_out            expected_results [$];

    int fail_count = 0;
    int result_index = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    flow_lookup_learn_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic t_flk_out predict_lookup(input t_flk_in key);
        t_flk_out    res;
        logic [31:0] id;
        res = '0;
        for (int i = 0; i < learned_count; i++) begin
            if (flow_table[i] == key) begin
                id = i + 1;
                res.flow_id = id[FLOW_ID_W-1:0];
                return res;
            end
        end
        if (learned_count >= FLOW_ENTRIES) begin
            res.table_full = 1'b1;
            return res;
        end
        flow_table[learned_count] = key;
        learned_count++;
        id = learned_count;
        res.flow_id = id[FLOW_ID_W-1:0];
        res.new_flow = 1'b1;
        res.new_policy = policy_reg;
        return res;
    endfunction

    function automatic t_flk_in random_key();
        t_flk_in k;
        k.src_addr = $urandom;
        k.dst_addr = $urandom;
        k.src_port = 16'($urandom_range(0, 16'hFFFF));
        k.dst_port = 16'($urandom_range(0, 16'hFFFF));
        k.protocol = 8'($urandom_range(0, 8'hFF));
        return k;
    endfunction

    function automatic t_flk_in near_miss_key();
        logic [KEY_W-1:0] bits;
        bits = flow_table[$urandom_range(0, learned_count - 1)];
        bits[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        return t_flk_in'(bits);
    endfunction

    function automatic t_flk_in mixed_key(input int new_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < new_pct || learned_count == 0)
            return random_key();
        if (r < new_pct + 10)
            return near_miss_key();
        return flow_table[$urandom_range(0, learned_count - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", result_index, what, got, want);
        fail_count++;
    endtask

    task automatic send_flow(input t_flk_in key);
        int gap_cycles;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_cycles > 0) begin
                in_valid <= 1'b0;
                repeat (gap_cycles) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= key;
        do @(posedge clk); while (in_stall !== 1'b0);
        expected_results.push_back(predict_lookup(key));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_policy(input logic [POLICY_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        policy_reg = value;
    endtask

    // policy still at its reset value
    task automatic test_reset_policy();
        send_flow('0);
        send_flow('0);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        t_flk_in k;
        write_policy(16'hFFFF);
        send_flow('1);
        k = '0; k.src_addr = '1; send_flow(k);
        k = '0; k.dst_addr = '1; send_flow(k);
        k = '0; k.src_port = '1; send_flow(k);
        k = '0; k.dst_port = '1; send_flow(k);
        k = '0; k.protocol = '1; send_flow(k);
        k = '1; k.protocol = '0; send_flow(k);
        send_flow('1);
        send_flow('0);
        k = '0; k.protocol = '1; send_flow(k);
        wait_drained();
    endtask

    task automatic test_random_learning(input logic [POLICY_W-1:0] policy, input int count);
        write_policy(policy);
        repeat (count) send_flow(mixed_key(15));
        wait_drained();
    endtask

    task automatic test_fill_table();
        t_flk_in k;
        write_policy(16'($urandom));
        while (learned_count < FLOW_ENTRIES) send_flow(random_key());
        send_flow(random_key());
        send_flow(near_miss_key());
        send_flow(flow_table[0]);
        send_flow(flow_table[FLOW_ENTRIES - 1]);
        k = flow_table[FLOW_ENTRIES - 1];
        k.protocol = ~k.protocol;
        send_flow(k);
        send_flow('1);
        wait_drained();
    endtask

    task automatic test_random_full(input int count);
        write_policy(16'($urandom));
        repeat (count) send_flow(mixed_key(30));
        wait_drained();
    endtask

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk) begin
        t_flk_out want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no pending lookup",
                                32'(out_data.flow_id), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (out_data.flow_id !== want.flow_id)
                    report_mismatch("flow_id", 32'(out_data.flow_id), 32'(want.flow_id));
                if (out_data.new_flow !== want.new_flow)
                    report_mismatch("new_flow", 32'(out_data.new_flow), 32'(want.new_flow));
                if (out_data.new_policy !== want.new_policy)
                    report_mismatch("new_policy", 32'(out_data.new_policy),
                                    32'(want.new_policy));
                if (out_data.table_full !== want.table_full)
                    report_mismatch("table_full", 32'(out_data.table_full),
                                    32'(want.table_full));
            end
            result_index++;
        end
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_policy();
        test_field_extremes();
        test_random_learning(16'h0000, 170);
        test_random_learning(16'h8000, 170);
        test_random_learning(16'($urandom), 170);
        test_random_learning(16'h0001, 170);
        test_fill_table();
        test_random_full(420);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
